// File: rtl/core/omnr_pkg.sv
// Package for the omega network route and conflict block.
// Holds field widths, switch setting codes and the beat structs; no dependencies.
`default_nettype none

package omnr_pkg;

  localparam int unsigned PortW         = 4;
  localparam int unsigned LevelW        = 3;
  localparam int unsigned SwW           = 5;
  localparam int unsigned SetW          = 2;
  localparam int unsigned LevelsDefault = 4;

  localparam logic [SetW-1:0] SetUpper = 2'd0;
  localparam logic [SetW-1:0] SetLower = 2'd3;

  // Input beat: one connection request.
  typedef struct packed {
    logic [PortW-1:0] source_port;
    logic [PortW-1:0] dest_port;
  } req_t;

  // Output beat: one per stage.
  typedef struct packed {
    logic [LevelW-1:0] stage_level;
    logic [SwW-1:0]    switch_index;
    logic [SetW-1:0]   switch_setting;
    logic              conflict;
    logic [PortW-1:0]  prior_source;
    logic [PortW-1:0]  prior_dest;
    logic              last;
  } res_t;

  // Connection travelling down the chain of stage cells.
  typedef struct packed {
    logic             valid;
    logic [PortW-1:0] src;
    logic [PortW-1:0] dst;
  } tok_t;

endpackage

`default_nettype wire

// File: rtl/core/omega_network_route_conflict_top.sv
// Omega network destination-tag router with switch conflict reporting.
// Results: an accepted start beat is registered in the top stage cell, its result in the output register;
// one result per cycle follows. A new request is taken only once the last one is in the stage 0 cell.
// Reset: asynchronous, active low; clears all claims, busy and the result strobe.
// Results are strobed for one cycle; the receiver cannot stall.
// Depends on omnr_pkg and omnr_cell.
`default_nettype none

module omega_network_route_conflict_top import omnr_pkg::*; #(
  parameter int unsigned LEVELS = LevelsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      res_strobe_o,
  output res_t      res_o
);

  // Chain links: link[LEVELS] feeds the top stage cell, link[l] leaves cell l.
  tok_t              tok_link [LEVELS+1];
  logic [LEVELS-1:0] pos_link [LEVELS+1];
  res_t              cell_res [LEVELS];
  logic [LEVELS-1:0] active;
  logic [LEVELS-1:0] src_pos;

  logic              res_strobe_q;
  res_t              res_q;
  logic              res_strobe_d;
  res_t              res_d;

  // Accept a request into the top stage cell.
  assign tok_link[LEVELS] = '{valid: start && !busy,
                              src:   req_i.source_port,
                              dst:   req_i.dest_port};

  // Position entering the top stage: source port masked to the network, then shuffled.
  generate
    if (LEVELS > PortW) begin : g_wide
      assign src_pos = {{(LEVELS-PortW){1'b0}}, req_i.source_port};
    end else begin : g_narrow
      assign src_pos = req_i.source_port[LEVELS-1:0];
    end
    if (LEVELS > 1) begin : g_shuf
      assign pos_link[LEVELS] = {src_pos[LEVELS-2:0], src_pos[LEVELS-1]};
    end else begin : g_shuf1
      assign pos_link[LEVELS] = src_pos;
    end
  endgenerate

  // One cell per stage; the connection moves down one cell a cycle.
  for (genvar l = 0; l < LEVELS; l++) begin : g_cell
    omnr_cell #(
      .LEVELS(LEVELS),
      .LEVEL (l)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (tok_link[l+1]),
      .pos_i (pos_link[l+1]),
      .tok_o (tok_link[l]),
      .pos_o (pos_link[l]),
      .res_o (cell_res[l])
    );
    assign active[l] = tok_link[l].valid;
  end

  // Busy until the connection reaches stage 0; the next one may then enter the top cell.
  generate
    if (LEVELS > 1) begin : g_busy
      assign busy = |active[LEVELS-1:1];
    end else begin : g_busy1
      assign busy = 1'b0;
    end
  endgenerate

  // At most one cell is active: select its result.
  always_comb begin
    res_strobe_d = |active;
    res_d        = cell_res[0];
    for (int unsigned l = 0; l < LEVELS; l++) begin
      if (active[l]) begin
        res_d = cell_res[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_strobe_q <= 1'b0;
    end else begin
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_strobe_o = res_strobe_q;
  assign res_o        = res_q;

`ifndef SYNTHESIS
  // Only one connection is ever inside the chain of cells.
  a_one_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(active))
    else $error("more than one stage cell active");

  // An accepted beat lands in the top stage cell.
  a_enter_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> active[LEVELS-1])
    else $error("accepted request did not enter top stage");

  // A result strobe follows a cycle with an active cell.
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (|active) |=> res_strobe_o)
    else $error("stage result dropped");

  // The last beat of a run comes from stage 0.
  a_last_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.last) |-> (res_o.stage_level == '0) && $past(active[0]))
    else $error("last flag on wrong stage");
`endif

endmodule

`default_nettype wire

// File: rtl/core/omnr_cell.sv
// One stage cell: holds the claim table of its stage and routes one connection a cycle.
// Depends on omnr_pkg.
`default_nettype none

module omnr_cell import omnr_pkg::*; #(
  parameter int unsigned LEVELS = LevelsDefault,
  parameter int unsigned LEVEL  = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tok_t              tok_i,
  input  wire logic [LEVELS-1:0] pos_i,
  output tok_t                   tok_o,
  output logic [LEVELS-1:0]      pos_o,
  output res_t                   res_o
);

  localparam int unsigned Half = 1 << (LEVELS - 1);
  localparam int unsigned IdxW = (LEVELS > 1) ? LEVELS - 1 : 1;

  tok_t              tok_q;
  logic [LEVELS-1:0] pos_q;

  logic [Half-1:0]   claimed_q;
  logic [Half-1:0]   lower_q;
  logic [PortW-1:0]  src_q [Half];
  logic [PortW-1:0]  dst_q [Half];

  logic [IdxW-1:0]   sw;
  logic              tag;
  logic              hit;

  // Hold the incoming connection for this cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      pos_q <= '0;
    end else begin
      tok_q <= tok_i;
      pos_q <= pos_i;
    end
  end

  generate
    if (LEVELS > 1) begin : g_sw
      assign sw = pos_q[LEVELS-1:1];
    end else begin : g_sw1
      assign sw = 1'b0;
    end
    if (LEVEL < PortW) begin : g_tag
      assign tag = tok_q.dst[LEVEL];
    end else begin : g_tag0
      assign tag = 1'b0;
    end
    // Next position is the shuffle of {switch, tag}.
    if (LEVELS > 2) begin : g_nxt
      assign pos_o = {sw[IdxW-2:0], tag, sw[IdxW-1]};
    end else if (LEVELS == 2) begin : g_nxt2
      assign pos_o = {tag, sw[0]};
    end else begin : g_nxt1
      assign pos_o = tag;
    end
  endgenerate

  assign hit = claimed_q[sw];

  always_comb begin
    res_o.stage_level    = LevelW'(LEVEL);
    res_o.switch_index   = SwW'(sw);
    res_o.switch_setting = tag ? SetLower : SetUpper;
    res_o.conflict       = hit && (lower_q[sw] != tag);
    res_o.prior_source   = hit ? src_q[sw] : '0;
    res_o.prior_dest     = hit ? dst_q[sw] : '0;
    res_o.last           = (LEVEL == 0);
  end

  assign tok_o = tok_q;

  // Claim the switch for the new connection.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      claimed_q <= '0;
    end else if (tok_q.valid) begin
      claimed_q[sw] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_q.valid) begin
      lower_q[sw] <= tag;
      src_q[sw]   <= tok_q.src;
      dst_q[sw]   <= tok_q.dst;
    end
  end

endmodule

`default_nettype wire
